### design/rms_pkg.sv
// Shared types, constants and the reciprocal table for the repeat mean/deviation block.
`timescale 1ns / 1ps
package rms_pkg;

  localparam int MAX_REPEATS = 8;
  localparam int SAMPLE_BITS = 24;

  localparam int FIELD_W     = 24;
  localparam int LANES       = 8;
  localparam int CNT_W       = 4;
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int RECIP_SHIFT = 32;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int VAR_W       = 2 * FIELD_W + 3;

  localparam logic [CNT_W-1:0] RESET_COUNT = 4'd3;

  // word index of each register (paddr[2])
  localparam logic REG_REPEAT_COUNT = 1'b0;

  typedef struct packed {
    logic [FIELD_W-1:0] wavelength;
    logic [FIELD_W-1:0] sample_0;
    logic [FIELD_W-1:0] sample_1;
    logic [FIELD_W-1:0] sample_2;
    logic [FIELD_W-1:0] sample_3;
    logic [FIELD_W-1:0] sample_4;
    logic [FIELD_W-1:0] sample_5;
    logic [FIELD_W-1:0] sample_6;
    logic [FIELD_W-1:0] sample_7;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] point_wavelength;
    logic [FIELD_W-1:0] mean_value;
    logic [FIELD_W-1:0] std_dev;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]   n;
    logic [RECIP_W-1:0] recip;
  } cnt_t;

  typedef struct packed {
    logic [FIELD_W-1:0]            wavelength;
    logic [LANES-1:0][FIELD_W-1:0] smp;
    logic [FIELD_W-1:0]            mean;
  } mean_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] wavelength;
    logic [FIELD_W-1:0] mean;
    logic [VAR_W-1:0]   variance;
  } var_item_t;

  // ceil(2^32 / n): floor(x * recip >> 32) is exact for x below 2^29
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'h0_8000_0000;
      4'd3:    r = 33'h0_5555_5556;
      4'd4:    r = 33'h0_4000_0000;
      4'd5:    r = 33'h0_3333_3334;
      4'd6:    r = 33'h0_2AAA_AAAB;
      4'd7:    r = 33'h0_2492_4925;
      4'd8:    r = 33'h0_2000_0000;
      default: r = 33'h1_0000_0000;
    endcase
    return r;
  endfunction

endpackage

### design/rms_cfg.sv
// Configuration register file: repeat count and its clamped count/reciprocal.
`timescale 1ns / 1ps
module rms_cfg #(
  parameter int MAX_REPEATS = rms_pkg::MAX_REPEATS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rms_pkg::ADDR_W-1:0]  paddr,
  input  logic [rms_pkg::DATA_W-1:0]  pwdata,
  output logic [rms_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output rms_pkg::cnt_t               cnt
);

  logic [rms_pkg::CNT_W-1:0] repeat_count;
  logic [rms_pkg::CNT_W-1:0] repeat_count_next;
  logic [rms_pkg::CNT_W-1:0] n_next;
  rms_pkg::cnt_t             cnt_next;
  logic                      wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite && (paddr[2] == rms_pkg::REG_REPEAT_COUNT);

  always_comb begin
    repeat_count_next = wr ? pwdata[rms_pkg::CNT_W-1:0] : repeat_count;
    if (repeat_count_next == '0) begin
      n_next = rms_pkg::CNT_W'(1);
    end else if (repeat_count_next > rms_pkg::CNT_W'(MAX_REPEATS)) begin
      n_next = rms_pkg::CNT_W'(MAX_REPEATS);
    end else begin
      n_next = repeat_count_next;
    end
    cnt_next.n     = n_next;
    cnt_next.recip = rms_pkg::recip(n_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count <= rms_pkg::RESET_COUNT;
      cnt.n        <= (rms_pkg::RESET_COUNT > rms_pkg::CNT_W'(MAX_REPEATS)) ?
                      rms_pkg::CNT_W'(MAX_REPEATS) : rms_pkg::RESET_COUNT;
      cnt.recip    <= rms_pkg::recip((rms_pkg::RESET_COUNT > rms_pkg::CNT_W'(MAX_REPEATS)) ?
                      rms_pkg::CNT_W'(MAX_REPEATS) : rms_pkg::RESET_COUNT);
    end else begin
      repeat_count <= repeat_count_next;
      cnt          <= cnt_next;
    end
  end

  assign prdata = (paddr[2] == rms_pkg::REG_REPEAT_COUNT) ?
                  rms_pkg::DATA_W'(repeat_count) : '0;

endmodule

### design/rms_mean.sv
// Mean pipeline: sample select, sum, reciprocal multiply (three stages).
`timescale 1ns / 1ps
module rms_mean #(
  parameter int MAX_REPEATS = rms_pkg::MAX_REPEATS,
  parameter int SAMPLE_BITS = rms_pkg::SAMPLE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  rms_pkg::cnt_t       cnt,
  input  logic                up_valid,
  output logic                up_ready,
  input  rms_pkg::in_item_t   up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rms_pkg::mean_item_t dn_data
);

  localparam int FW    = rms_pkg::FIELD_W;
  localparam int LANES = rms_pkg::LANES;
  localparam int SW    = (SAMPLE_BITS < FW) ? SAMPLE_BITS : FW;
  localparam int SUMW  = SW + $clog2(MAX_REPEATS);
  localparam int PW    = SUMW + rms_pkg::RECIP_W;

  logic [LANES-1:0][FW-1:0] lane;
  logic [LANES-1:0][SW-1:0] smp_c;
  logic [SUMW-1:0]          sum_c;

  logic v1, v2, v3;
  logic en1, en2, en3;
  logic [FW-1:0]            wl1, wl2, wl3;
  logic [LANES-1:0][SW-1:0] smp1, smp2, smp3;
  logic [SUMW-1:0]          sum2;
  logic [PW-1:0]            prod3;

  assign lane[0] = up_data.sample_0;
  assign lane[1] = up_data.sample_1;
  assign lane[2] = up_data.sample_2;
  assign lane[3] = up_data.sample_3;
  assign lane[4] = up_data.sample_4;
  assign lane[5] = up_data.sample_5;
  assign lane[6] = up_data.sample_6;
  assign lane[7] = up_data.sample_7;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      smp_c[k] = (rms_pkg::CNT_W'(k) < cnt.n) ? lane[k][SW-1:0] : '0;
    end
  end

  always_comb begin
    sum_c = '0;
    for (int k = 0; k < LANES; k++) begin
      sum_c = sum_c + SUMW'(smp1[k]);
    end
  end

  assign en3      = !v3 || dn_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign up_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= up_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      wl1  <= up_data.wavelength;
      smp1 <= smp_c;
    end
    if (en2) begin
      wl2  <= wl1;
      smp2 <= smp1;
      sum2 <= sum_c;
    end
    if (en3) begin
      wl3   <= wl2;
      smp3  <= smp2;
      prod3 <= PW'(sum2) * PW'(cnt.recip);
    end
  end

  assign dn_valid = v3;

  always_comb begin
    dn_data.wavelength = wl3;
    for (int k = 0; k < LANES; k++) begin
      dn_data.smp[k] = FW'(smp3[k]);
    end
    dn_data.mean = FW'(prod3 >> rms_pkg::RECIP_SHIFT);
  end

endmodule

### design/rms_var.sv
// Variance pipeline: squared deviations, sum, split division by the count.
`timescale 1ns / 1ps
module rms_var #(
  parameter int MAX_REPEATS = rms_pkg::MAX_REPEATS,
  parameter int SAMPLE_BITS = rms_pkg::SAMPLE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  rms_pkg::cnt_t       cnt,
  input  logic                up_valid,
  output logic                up_ready,
  input  rms_pkg::mean_item_t up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rms_pkg::var_item_t  dn_data
);

  localparam int FW    = rms_pkg::FIELD_W;
  localparam int LANES = rms_pkg::LANES;
  localparam int RS    = rms_pkg::RECIP_SHIFT;
  localparam int SW    = (SAMPLE_BITS < FW) ? SAMPLE_BITS : FW;
  localparam int SQW   = 2 * SW;
  localparam int VW    = SQW + $clog2(MAX_REPEATS);
  localparam int LW    = VW / 2;
  localparam int HW    = VW - LW;
  localparam int XW    = LW + 3;
  localparam int PHW   = HW + rms_pkg::RECIP_W;
  localparam int P2W   = XW + rms_pkg::RECIP_W;

  logic [LANES-1:0][SQW-1:0] sq_c;
  logic [SW-1:0]             d;
  logic [VW-1:0]             vsum_c;
  logic [HW-1:0]             qh_c;
  logic [2:0]                qn;
  logic [2:0]                rh;

  logic va, vb, vc, vd, ve;
  logic ena, enb, enc, end_, ene;
  logic [FW-1:0]             wla, wlb, wlc, wld, wle;
  logic [FW-1:0]             mna, mnb, mnc, mnd, mne;
  logic [LANES-1:0][SQW-1:0] sqa;
  logic [VW-1:0]             vsumb;
  logic [PHW-1:0]            phc;
  logic [2:0]                vh3c;
  logic [LW-1:0]             vlc;
  logic [HW-1:0]             qhd, qhe;
  logic [XW-1:0]             x2d;
  logic [P2W-1:0]            p2e;

  always_comb begin
    d = '0;
    for (int k = 0; k < LANES; k++) begin
      if (up_data.smp[k][SW-1:0] >= up_data.mean[SW-1:0]) begin
        d = up_data.smp[k][SW-1:0] - up_data.mean[SW-1:0];
      end else begin
        d = up_data.mean[SW-1:0] - up_data.smp[k][SW-1:0];
      end
      sq_c[k] = (rms_pkg::CNT_W'(k) < cnt.n) ? SQW'(d) * SQW'(d) : '0;
    end
  end

  always_comb begin
    vsum_c = '0;
    for (int k = 0; k < LANES; k++) begin
      vsum_c = vsum_c + VW'(sqa[k]);
    end
  end

  // high part quotient, remainder (below n) carried into the low part
  assign qh_c = phc[RS +: HW];
  assign qn   = qh_c[2:0] * cnt.n[2:0];
  assign rh   = vh3c - qn;

  assign ene      = !ve || dn_ready;
  assign end_     = !vd || ene;
  assign enc      = !vc || end_;
  assign enb      = !vb || enc;
  assign ena      = !va || enb;
  assign up_ready = ena;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      if (ena)  va <= up_valid;
      if (enb)  vb <= va;
      if (enc)  vc <= vb;
      if (end_) vd <= vc;
      if (ene)  ve <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      wla <= up_data.wavelength;
      mna <= up_data.mean;
      sqa <= sq_c;
    end
    if (enb) begin
      wlb   <= wla;
      mnb   <= mna;
      vsumb <= vsum_c;
    end
    if (enc) begin
      wlc  <= wlb;
      mnc  <= mnb;
      phc  <= PHW'(vsumb[VW-1:LW]) * PHW'(cnt.recip);
      vh3c <= vsumb[LW +: 3];
      vlc  <= vsumb[LW-1:0];
    end
    if (end_) begin
      wld <= wlc;
      mnd <= mnc;
      qhd <= qh_c;
      x2d <= {rh, vlc};
    end
    if (ene) begin
      wle <= wld;
      mne <= mnd;
      qhe <= qhd;
      p2e <= P2W'(x2d) * P2W'(cnt.recip);
    end
  end

  assign dn_valid            = ve;
  assign dn_data.wavelength  = wle;
  assign dn_data.mean        = mne;
  assign dn_data.variance    = rms_pkg::VAR_W'({qhe, p2e[RS +: LW]});

endmodule

### design/rms_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rms_sqrt #(
  parameter int MAX_REPEATS = rms_pkg::MAX_REPEATS,
  parameter int SAMPLE_BITS = rms_pkg::SAMPLE_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  rms_pkg::var_item_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rms_pkg::out_item_t dn_data
);

  localparam int FW   = rms_pkg::FIELD_W;
  localparam int SW   = (SAMPLE_BITS < FW) ? SAMPLE_BITS : FW;
  localparam int VW   = 2 * SW + $clog2(MAX_REPEATS);
  localparam int RW   = (VW + 1) / 2;
  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 2;

  logic [RW-1:0] v;
  logic [RW-1:0] en;
  logic [RW-1:0] src_v;

  logic [RW-1:0]   q       [RW];
  logic [REMW-1:0] rem     [RW];
  logic [RADW-1:0] rad     [RW];
  logic [FW-1:0]   wl      [RW];
  logic [FW-1:0]   mn      [RW];

  logic [RW-1:0]   src_q   [RW];
  logic [REMW-1:0] src_rem [RW];
  logic [RADW-1:0] src_rad [RW];
  logic [FW-1:0]   src_wl  [RW];
  logic [FW-1:0]   src_mn  [RW];

  logic [RW-1:0]   nq      [RW];
  logic [REMW-1:0] nrem    [RW];
  logic [RADW-1:0] nrad    [RW];
  logic [REMW-1:0] r2      [RW];
  logic [REMW-1:0] trial   [RW];

  assign src_v[0]   = up_valid;
  assign src_q[0]   = '0;
  assign src_rem[0] = '0;
  assign src_rad[0] = RADW'(up_data.variance[VW-1:0]);
  assign src_wl[0]  = up_data.wavelength;
  assign src_mn[0]  = up_data.mean;

  for (genvar i = 1; i < RW; i++) begin : g_src
    assign src_v[i]   = v[i-1];
    assign src_q[i]   = q[i-1];
    assign src_rem[i] = rem[i-1];
    assign src_rad[i] = rad[i-1];
    assign src_wl[i]  = wl[i-1];
    assign src_mn[i]  = mn[i-1];
  end

  assign en[RW-1] = !v[RW-1] || dn_ready;
  for (genvar i = 0; i < RW - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end
  assign up_ready = en[0];

  always_comb begin
    for (int i = 0; i < RW; i++) begin
      r2[i]    = {src_rem[i][REMW-3:0], src_rad[i][RADW-1 -: 2]};
      trial[i] = {src_q[i], 2'b01};
      if (r2[i] >= trial[i]) begin
        nrem[i] = r2[i] - trial[i];
        nq[i]   = {src_q[i][RW-2:0], 1'b1};
      end else begin
        nrem[i] = r2[i];
        nq[i]   = {src_q[i][RW-2:0], 1'b0};
      end
      nrad[i] = src_rad[i] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < RW; i++) begin
        if (en[i]) v[i] <= src_v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RW; i++) begin
      if (en[i]) begin
        q[i]   <= nq[i];
        rem[i] <= nrem[i];
        rad[i] <= nrad[i];
        wl[i]  <= src_wl[i];
        mn[i]  <= src_mn[i];
      end
    end
  end

  assign dn_valid                 = v[RW-1];
  assign dn_data.point_wavelength = wl[RW-1];
  assign dn_data.mean_value       = mn[RW-1];
  assign dn_data.std_dev          = FW'(q[RW-1]);

endmodule

### design/repeat_mean_stddev.sv
// Pipeline: 3 mean stages, 5 variance stages, one square-root stage per result bit.
// Throughput: one transfer per cycle on both channels; each stage holds when the next is full.
// Reset (rst, synchronous): pipeline emptied, repeat_count back to 3.
// Top level: mean and population standard deviation of repeated samples.
`timescale 1ns / 1ps
module repeat_mean_stddev #(
  parameter int MAX_REPEATS = rms_pkg::MAX_REPEATS,
  parameter int SAMPLE_BITS = rms_pkg::SAMPLE_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rms_pkg::ADDR_W-1:0] paddr,
  input  logic [rms_pkg::DATA_W-1:0] pwdata,
  output logic [rms_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       sample_valid,
  output logic                       sample_ready,
  input  rms_pkg::in_item_t          sample_data,
  output logic                       stat_valid,
  input  logic                       stat_ready,
  output rms_pkg::out_item_t         stat_data
);

  rms_pkg::cnt_t       cnt;
  logic                m_valid, m_ready;
  rms_pkg::mean_item_t m_data;
  logic                vr_valid, vr_ready;
  rms_pkg::var_item_t  vr_data;

  rms_cfg #(.MAX_REPEATS(MAX_REPEATS)) u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cnt (cnt)
  );

  rms_mean #(.MAX_REPEATS(MAX_REPEATS), .SAMPLE_BITS(SAMPLE_BITS)) u_mean (
    .clk, .rst, .cnt (cnt),
    .up_valid (sample_valid), .up_ready (sample_ready), .up_data (sample_data),
    .dn_valid (m_valid),      .dn_ready (m_ready),      .dn_data (m_data)
  );

  rms_var #(.MAX_REPEATS(MAX_REPEATS), .SAMPLE_BITS(SAMPLE_BITS)) u_var (
    .clk, .rst, .cnt (cnt),
    .up_valid (m_valid),  .up_ready (m_ready),  .up_data (m_data),
    .dn_valid (vr_valid), .dn_ready (vr_ready), .dn_data (vr_data)
  );

  rms_sqrt #(.MAX_REPEATS(MAX_REPEATS), .SAMPLE_BITS(SAMPLE_BITS)) u_sqrt (
    .clk, .rst,
    .up_valid (vr_valid),   .up_ready (vr_ready),   .up_data (vr_data),
    .dn_valid (stat_valid), .dn_ready (stat_ready), .dn_data (stat_data)
  );

endmodule

### design/rms_checker.sv
// Port-level checks for repeat_mean_stddev and their bind.
`timescale 1ns / 1ps
module rms_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [rms_pkg::ADDR_W-1:0] paddr,
  input logic [rms_pkg::DATA_W-1:0] pwdata,
  input logic [rms_pkg::DATA_W-1:0] prdata,
  input logic                       stat_valid,
  input logic                       stat_ready,
  input rms_pkg::out_item_t         stat_data
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stat_valid && !stat_ready |=> stat_valid && $stable(stat_data))
    else $error("result transfer dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !stat_valid)
    else $error("result offered straight after reset");

  a_read_back: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == rms_pkg::REG_REPEAT_COUNT)
    |=> paddr[2] != rms_pkg::REG_REPEAT_COUNT ||
        prdata[rms_pkg::CNT_W-1:0] == $past(pwdata[rms_pkg::CNT_W-1:0]))
    else $error("repeat_count read back differs from last write");

  a_read_upper: assert property (@(posedge clk) disable iff (rst)
    prdata[rms_pkg::DATA_W-1:rms_pkg::CNT_W] == '0)
    else $error("unused register bits read non-zero");

endmodule

bind repeat_mean_stddev rms_checker u_rms_checker (
  .clk        (clk),
  .rst        (rst),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .stat_valid (stat_valid),
  .stat_ready (stat_ready),
  .stat_data  (stat_data)
);

### tb/repeat_mean_stddev_tb.sv
// Self-checking testbench for the repeat mean and standard deviation block.
`timescale 1ns / 1ps
module repeat_mean_stddev_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [rms_pkg::ADDR_W-1:0] paddr = '0;
  logic [rms_pkg::DATA_W-1:0] pwdata = '0;
  logic [rms_pkg::DATA_W-1:0] prdata;
  logic pready;
  logic sample_valid = 1'b0;
  logic sample_ready;
  rms_pkg::in_item_t sample_data = '0;
  logic stat_valid;
  logic stat_ready = 1'b0;
  rms_pkg::out_item_t stat_data;

  rms_pkg::in_item_t pending_points[$];
  rms_pkg::out_item_t expected_stats[$];
  logic [rms_pkg::CNT_W-1:0] repeat_reg;
  int error_count = 0;
  int drive_gap = 0;
  int sink_gap = 0;
  bit stimulus_done = 1'b0;
  bit offer = 1'b0;
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;

  repeat_mean_stddev dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--)
      if (((r | (64'd1 << b)) * (r | (64'd1 << b))) <= v) r |= 64'd1 << b;
    return r;
  endfunction

  // variance fits easily: the sum of squares stays below 8 * (2^24)^2 = 2^51
  function automatic rms_pkg::out_item_t point_stats(input rms_pkg::in_item_t p,
                                                     input logic [rms_pkg::CNT_W-1:0] cnt);
    logic [rms_pkg::FIELD_W-1:0] s [8];
    logic [63:0] n, sum, mean, d, acc, root;
    rms_pkg::out_item_t o;
    s = '{p.sample_0, p.sample_1, p.sample_2, p.sample_3,
          p.sample_4, p.sample_5, p.sample_6, p.sample_7};
    n = (cnt == 0) ? 1 : (cnt > rms_pkg::MAX_REPEATS) ? rms_pkg::MAX_REPEATS : cnt;
    sum = 0;
    for (int k = 0; k < n; k++) sum += s[k];
    mean = sum / n;
    acc = 0;
    for (int k = 0; k < n; k++) begin
      d = (s[k] >= mean) ? s[k] - mean : mean - s[k];
      acc += d * d;
    end
    root = floor_sqrt(acc / n);
    o.point_wavelength = p.wavelength;
    o.mean_value = mean[rms_pkg::FIELD_W-1:0];
    o.std_dev = root[rms_pkg::FIELD_W-1:0];
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [rms_pkg::FIELD_W-1:0] got,
                                 input logic [rms_pkg::FIELD_W-1:0] want);
    $display("%0t: %s mismatch: got %h expected %h", $time, what, got, want);
    error_count++;
  endtask

  always @(negedge clk) begin
    if (!rst) begin
      if (in_taken) begin
        in_taken = 1'b0;
        offer = 1'b0;
        drive_gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) drive_gap = 0;
      end
      if (!offer) begin
        if (drive_gap > 0) drive_gap--;
        else if (pending_points.size() > 0) begin
          sample_data <= pending_points.pop_front();
          offer = 1'b1;
        end
      end
      sample_valid <= offer;
      if (out_taken) begin
        out_taken = 1'b0;
        sink_gap = $urandom_range(0, 7);
      end
      if (sink_gap > 0) begin
        sink_gap--;
        stat_ready <= 1'b0;
      end else begin
        stat_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        expected_stats = {expected_stats, point_stats(sample_data, repeat_reg)};
        in_taken = 1'b1;
      end
      if (stat_valid && stat_ready) begin
        out_taken = 1'b1;
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected transfer", stat_data.point_wavelength, '0);
        end else begin
          rms_pkg::out_item_t e;
          e = expected_stats.pop_front();
          if (stat_data.point_wavelength !== e.point_wavelength)
            report_mismatch("wavelength", stat_data.point_wavelength, e.point_wavelength);
          if (stat_data.mean_value !== e.mean_value)
            report_mismatch("mean", stat_data.mean_value, e.mean_value);
          if (stat_data.std_dev !== e.std_dev)
            report_mismatch("std_dev", stat_data.std_dev, e.std_dev);
        end
      end
    end
  end

  task automatic write_count(input logic [3:0] v);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {rms_pkg::REG_REPEAT_COUNT, 2'b00}; pwdata <= {$urandom} & 32'hFFFF_FFF0 | v;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    repeat_reg = v;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic logic [rms_pkg::FIELD_W-1:0] rand_sample(input int style,
                                                              input logic [23:0] base);
    case (style)
      0: return rms_pkg::FIELD_W'($urandom);
      1: return rms_pkg::FIELD_W'(base + $urandom_range(0, 255) - 128);
      2: return ($urandom_range(0, 1)) ? 24'hFFFFFF : 24'h000000;
      default: return rms_pkg::FIELD_W'(base ^ ($urandom & 24'h00000F));
    endcase
  endfunction

  task automatic queue_point(input int style);
    rms_pkg::in_item_t p;
    logic [23:0] base;
    base = 24'($urandom);
    p.wavelength = rms_pkg::FIELD_W'($urandom);
    p.sample_0 = rand_sample(style, base); p.sample_1 = rand_sample(style, base);
    p.sample_2 = rand_sample(style, base); p.sample_3 = rand_sample(style, base);
    p.sample_4 = rand_sample(style, base); p.sample_5 = rand_sample(style, base);
    p.sample_6 = rand_sample(style, base); p.sample_7 = rand_sample(style, base);
    pending_points = {pending_points, p};
  endtask

  task automatic drain;
    wait (pending_points.size() == 0 && !sample_valid && expected_stats.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    rms_pkg::in_item_t p;
    logic [3:0] phases [12];
    repeat_reg = rms_pkg::RESET_COUNT;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    // directed: extremes under the reset count, then single-sample and saturated counts
    p = '0; pending_points = {pending_points, p};
    p = '1; pending_points = {pending_points, p};
    p = '0; p.wavelength = 24'hABCDEF; p.sample_0 = 24'hFFFFFF; p.sample_2 = 24'hFFFFFF;
    pending_points = {pending_points, p};
    p = '1; p.sample_1 = 0; pending_points = {pending_points, p};
    p = '0; p.sample_0 = 24'h000100; p.sample_1 = 24'h000101; p.sample_2 = 24'h000101;
    pending_points = {pending_points, p};
    drain();
    phases = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd9, 4'd2, 4'd4, 4'd5, 4'd6, 4'd7, 4'd3, 4'd8};
    foreach (phases[i]) begin
      write_count(phases[i]);
      if (i < 4) begin
        p = '1; p.sample_0 = 0; pending_points = {pending_points, p};
        p = '0; p.sample_7 = 24'hFFFFFF; pending_points = {pending_points, p};
      end
      repeat (120) queue_point($urandom_range(0, 3));
      drain();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
